// ----- rtl/sbeu_pkg.sv -----
`default_nettype none
package sbeu_pkg;

	typedef enum logic [5:0] {
		OP_NOP = 6'd0, OP_LDC_I4 = 6'd1, OP_LDC_R4 = 6'd2, OP_DUP = 6'd3, OP_POP = 6'd4,
		OP_ADD = 6'd5, OP_SUB = 6'd6, OP_MUL = 6'd7, OP_DIV = 6'd8, OP_REM = 6'd9,
		OP_AND = 6'd10, OP_OR = 6'd11, OP_XOR = 6'd12, OP_SHL = 6'd13, OP_SHR = 6'd14,
		OP_NEG = 6'd15, OP_NOT = 6'd16, OP_CEQ = 6'd17, OP_CGT = 6'd18, OP_CLT = 6'd19,
		OP_BR = 6'd20, OP_BRFALSE = 6'd21, OP_BRTRUE = 6'd22, OP_CALL = 6'd23,
		OP_RET = 6'd24, OP_BOX = 6'd25, OP_NEWARR = 6'd26, OP_LDLEN = 6'd27,
		OP_LDFLD = 6'd28, OP_STFLD = 6'd29, OP_LDSFLD = 6'd30, OP_STSFLD = 6'd31,
		OP_NEWOBJ = 6'd32, OP_CASTCLASS = 6'd33, OP_ISINST = 6'd34, OP_THROW = 6'd35,
		OP_BEGIN = 6'd36
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_DIV, S_WRITE, S_OUT
	} fsm_t;

endpackage
`default_nettype wire

// ----- rtl/stack_bytecode_execute_unit.sv -----
`default_nettype none
// A word is accepted in the idle state and then passes through stack read, execute, write back
// and output; a new word is accepted only once the unit has returned to the idle state.
// The result word is registered in the output state; div and rem with a nonzero divisor
// also pass through the bit-serial divider, and a stalled output holds the unit.
// Stack memories: two read ports for integers, one for addresses, one write port each.
// Reset clears the stack depths, the pc and the halted flag; stack memories are not cleared.
module stack_bytecode_execute_unit #(
	parameter int INT_STACK_DEPTH = 256,
	parameter int ADDR_STACK_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [5:0]         req_type,
	input  wire logic [31:0]        operand,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [31:0]             next_pc,
	output logic                    halted,
	output logic signed [31:0]      int_top,
	output logic [8:0]              int_count,
	output logic [31:0]             addr_top,
	output logic [8:0]              addr_count,
	output logic [1:0]              status
);

	localparam int IW = $clog2(INT_STACK_DEPTH);
	localparam int AW = $clog2(ADDR_STACK_DEPTH);
	localparam int ISW = $clog2(INT_STACK_DEPTH + 1);
	localparam int ASW = $clog2(ADDR_STACK_DEPTH + 1);
	localparam logic [ISW-1:0] IFULL = ISW'(INT_STACK_DEPTH);
	localparam logic [ASW-1:0] AFULL = ASW'(ADDR_STACK_DEPTH);

	logic [31:0] int_mem [INT_STACK_DEPTH];
	logic [31:0] addr_mem [ADDR_STACK_DEPTH];

	sbeu_pkg::fsm_t state_q, state_d;
	logic [5:0] op_q;
	logic [31:0] opnd_q;
	logic [ISW-1:0] isp_q, isp_d;
	logic [ASW-1:0] asp_q, asp_d;
	logic [31:0] pc_q, pc_d;
	logic stop_q, stop_d;

	// Operand reads: top, second and address top.
	logic [IW-1:0] ira0, ira1;
	logic [AW-1:0] ara0;
	logic [31:0] ird0, ird1, ard0;

	// Write ports.
	logic iwe, awe;
	logic [IW-1:0] iwa;
	logic [AW-1:0] awa;
	logic [31:0] iwd, awd;

	logic [1:0] st_q, st_d;
	logic [31:0] ires_q, ires_d;
	logic ipush_q, ipush_d;
	logic adup_q, adup_d;
	logic fwd_q;

	// Divider.
	logic [31:0] dq_q, dr_q, dd_q;
	logic [5:0] dcnt_q;
	logic dnq_q, dnr_q;
	logic div_start;
	logic [32:0] dtrial;

	logic [ISW-1:0] isp_m1, isp_m2;
	logic [ASW-1:0] asp_m1;
	assign isp_m1 = isp_q - ISW'(1);
	assign isp_m2 = isp_q - ISW'(2);
	assign asp_m1 = asp_q - ASW'(1);
	assign ira0 = isp_m1[IW-1:0];
	assign ira1 = isp_m2[IW-1:0];
	assign ara0 = asp_m1[AW-1:0];

	always_ff @(posedge clk) begin
		ird0 <= int_mem[ira0];
		ard0 <= addr_mem[ara0];
		if (iwe) begin
			int_mem[iwa] <= iwd;
		end
	end

	always_ff @(posedge clk) begin
		ird1 <= int_mem[ira1];
		if (awe) begin
			addr_mem[awa] <= awd;
		end
	end

	logic in_acc, out_busy;
	assign out_busy = out_valid && out_stall;
	assign in_stall = (state_q != sbeu_pkg::S_IDLE);
	assign in_acc = in_valid && !in_stall;

	logic [31:0] a, b, ra;
	logic a_ok, b_ok;
	assign b_ok = (isp_q != '0);
	assign a_ok = (isp_q > ISW'(1));
	assign b = b_ok ? ird0 : 32'd0;
	assign a = a_ok ? ird1 : 32'd0;
	assign ra = (asp_q != '0) ? ard0 : 32'd0;

	logic [31:0] ua, ub;
	assign ua = a[31] ? 32'd0 - a : a;
	assign ub = b[31] ? 32'd0 - b : b;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

	always_comb begin
		logic [31:0] r;
		logic [ISW-1:0] ib;
		logic [ISW-1:0] iab;
		state_d = state_q;
		isp_d = isp_q;
		asp_d = asp_q;
		pc_d = pc_q;
		stop_d = stop_q;
		st_d = st_q;
		ires_d = ires_q;
		ipush_d = 1'b0;
		adup_d = 1'b0;
		iwe = 1'b0;
		awe = 1'b0;
		iwa = isp_q[IW-1:0];
		awa = asp_q[AW-1:0];
		iwd = 32'd0;
		awd = 32'd0;
		div_start = 1'b0;
		r = 32'd0;
		ib = b_ok ? isp_m1 : '0;
		iab = a_ok ? isp_m2 : '0;
		unique case (state_q)
			sbeu_pkg::S_IDLE: begin
				if (in_acc) begin
					state_d = sbeu_pkg::S_READ;
				end
			end
			sbeu_pkg::S_READ: begin
				state_d = sbeu_pkg::S_EXEC;
			end
			sbeu_pkg::S_EXEC: begin
				st_d = sbeu_pkg::ST_OK;
				state_d = sbeu_pkg::S_WRITE;
				if (op_q == sbeu_pkg::OP_BEGIN) begin
					isp_d = '0;
					asp_d = '0;
					pc_d = 32'd0;
					stop_d = 1'b0;
				end else if (!stop_q) begin
					pc_d = pc_q + 32'd1;
					priority case (op_q)
						sbeu_pkg::OP_LDC_I4: begin
							ires_d = opnd_q;
							ipush_d = 1'b1;
						end
						sbeu_pkg::OP_DUP: begin
							if (asp_q == '0) begin
								awa = '0;
								awd = 32'd0;
								awe = 1'b1;
								asp_d = ASW'(1);
								adup_d = 1'b1;
							end else if (asp_q == AFULL) begin
								st_d = sbeu_pkg::ST_FULL;
							end else begin
								awd = ard0;
								awe = 1'b1;
								asp_d = asp_q + ASW'(1);
							end
						end
						sbeu_pkg::OP_POP, sbeu_pkg::OP_STSFLD: begin
							asp_d = (asp_q != '0) ? asp_m1 : '0;
						end
						sbeu_pkg::OP_ADD, sbeu_pkg::OP_SUB, sbeu_pkg::OP_MUL,
						sbeu_pkg::OP_AND, sbeu_pkg::OP_OR, sbeu_pkg::OP_XOR,
						sbeu_pkg::OP_SHL, sbeu_pkg::OP_SHR, sbeu_pkg::OP_CEQ,
						sbeu_pkg::OP_CGT, sbeu_pkg::OP_CLT: begin
							unique case (op_q)
								sbeu_pkg::OP_ADD: r = a + b;
								sbeu_pkg::OP_SUB: r = a - b;
								sbeu_pkg::OP_MUL: r = a * b;
								sbeu_pkg::OP_AND: r = a & b;
								sbeu_pkg::OP_OR:  r = a | b;
								sbeu_pkg::OP_XOR: r = a ^ b;
								sbeu_pkg::OP_SHL: r = a << b[4:0];
								sbeu_pkg::OP_SHR: r = 32'($signed(a) >>> b[4:0]);
								sbeu_pkg::OP_CEQ: r = {31'd0, a == b};
								sbeu_pkg::OP_CGT: r = {31'd0, $signed(a) > $signed(b)};
								default: r = {31'd0, $signed(a) < $signed(b)};
							endcase
							isp_d = iab;
							ires_d = r;
							ipush_d = 1'b1;
						end
						sbeu_pkg::OP_DIV, sbeu_pkg::OP_REM: begin
							isp_d = iab;
							if (b == 32'd0) begin
								ires_d = 32'd0;
								ipush_d = 1'b1;
								st_d = sbeu_pkg::ST_DIV_ZERO;
							end else begin
								div_start = 1'b1;
								state_d = sbeu_pkg::S_DIV;
							end
						end
						sbeu_pkg::OP_NEG: begin
							isp_d = ib;
							ires_d = 32'd0 - b;
							ipush_d = 1'b1;
						end
						sbeu_pkg::OP_NOT: begin
							isp_d = ib;
							ires_d = ~b;
							ipush_d = 1'b1;
						end
						sbeu_pkg::OP_BR: pc_d = opnd_q;
						sbeu_pkg::OP_BRFALSE: begin
							isp_d = ib;
							if (b == 32'd0) begin
								pc_d = opnd_q;
							end
						end
						sbeu_pkg::OP_BRTRUE: begin
							isp_d = ib;
							if (b != 32'd0) begin
								pc_d = opnd_q;
							end
						end
						sbeu_pkg::OP_RET, sbeu_pkg::OP_THROW: stop_d = 1'b1;
						sbeu_pkg::OP_LDFLD: begin
							if (ra != 32'd0) begin
								awa = ara0;
								awd = ra + opnd_q;
								awe = 1'b1;
							end else begin
								asp_d = (asp_q != '0) ? asp_m1 : '0;
							end
						end
						sbeu_pkg::OP_LDSFLD, sbeu_pkg::OP_NEWOBJ: begin
							if (asp_q == AFULL) begin
								st_d = sbeu_pkg::ST_FULL;
							end else begin
								awd = 32'd0;
								awe = 1'b1;
								asp_d = asp_q + ASW'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			sbeu_pkg::S_DIV: begin
				if (dcnt_q == 6'd32) begin
					ires_d = dnq_q ? (32'd0 - dq_q) : dq_q;
					if (op_q == sbeu_pkg::OP_REM) begin
						ires_d = dnr_q ? (32'd0 - dr_q) : dr_q;
					end
					ipush_d = 1'b1;
					state_d = sbeu_pkg::S_WRITE;
				end
			end
			sbeu_pkg::S_WRITE: begin
				if (ipush_q) begin
					if (isp_q == IFULL) begin
						st_d = sbeu_pkg::ST_FULL;
					end else begin
						iwe = 1'b1;
						iwd = ires_q;
						isp_d = isp_q + ISW'(1);
					end
				end
				if (adup_q) begin
					awd = 32'd0;
					awe = 1'b1;
					asp_d = asp_q + ASW'(1);
				end
				state_d = sbeu_pkg::S_OUT;
			end
			sbeu_pkg::S_OUT: begin
				// The integer top is taken from the write data when it was pushed in the write-back state.
				if (!out_busy) begin
					state_d = sbeu_pkg::S_IDLE;
				end
			end
			default: state_d = sbeu_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbeu_pkg::S_IDLE;
			isp_q <= '0;
			asp_q <= '0;
			pc_q <= 32'd0;
			stop_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			isp_q <= isp_d;
			asp_q <= asp_d;
			pc_q <= pc_d;
			stop_q <= stop_d;
			if (state_q == sbeu_pkg::S_OUT && !out_busy) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_d;
		ires_q <= ires_d;
		ipush_q <= ipush_d;
		adup_q <= adup_d;
		fwd_q <= iwe;
		if (in_acc) begin
			op_q <= req_type;
			opnd_q <= operand;
		end
		if (div_start) begin
			dq_q <= ua;
			dr_q <= 32'd0;
			dd_q <= ub;
			dcnt_q <= 6'd0;
			dnq_q <= a[31] ^ b[31];
			dnr_q <= a[31];
		end else if (state_q == sbeu_pkg::S_DIV && dcnt_q != 6'd32) begin
			dcnt_q <= dcnt_q + 6'd1;
			if (!dtrial[32]) begin
				dr_q <= dtrial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= {dr_q[30:0], dq_q[31]};
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
		if (state_q == sbeu_pkg::S_OUT && !out_busy) begin
			next_pc <= pc_q;
			halted <= stop_q;
			int_top <= (isp_q != '0) ? (fwd_q ? ires_q : ird0) : 32'd0;
			addr_top <= (asp_q != '0) ? ard0 : 32'd0;
			int_count <= 9'(isp_q);
			addr_count <= 9'(asp_q);
			status <= st_q;
		end
	end

endmodule
`default_nettype wire
